/* rtl/core/plkc_pkg.sv */
// Shared types and constants for the pinned LRU key cache.
package plkc_pkg;

   localparam int DEFAULT_ENTRIES = 16;
   localparam int DEFAULT_KEY_BITS = 32;

   localparam int CMD_W = 3;
   localparam int REQ_KEY_W = 32;
   localparam int SLOT_W = 4;
   localparam int STAMP_W = 32;
   localparam int STATUS_W = 2;
   localparam int CAP_W = 5;
   localparam int OCC_W = 5;
   localparam int CTR_W = 32;

   localparam int SLOT_MAX_W = 8;
   localparam int COUNT_MAX_W = 9;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNCACHED = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP = 3'd0,
      CMD_RELEASE = 3'd1,
      CMD_CLEAR = 3'd2,
      CMD_EVICT = 3'd3,
      CMD_STATS = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic match_found;
      logic [SLOT_MAX_W-1:0] match_slot;
      logic free_found;
      logic [SLOT_MAX_W-1:0] free_slot;
      logic old_found;
      logic [SLOT_MAX_W-1:0] old_slot;
      logic [COUNT_MAX_W-1:0] occupied;
      logic [COUNT_MAX_W-1:0] pinned_count;
   } scan_result_type;

endpackage

/* rtl/core/plkc_ram.sv */
// Generic single write port RAM with one registered read port.
module plkc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/plkc_scan.sv */
// Shared compare unit that takes one entry per cycle while step is high and keeps the running picks.
module plkc_scan #(
   parameter int ENTRIES = plkc_pkg::DEFAULT_ENTRIES,
   parameter int KEY_BITS = plkc_pkg::DEFAULT_KEY_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           init,
   input  logic                           step,
   input  logic [$clog2(ENTRIES)-1:0]     step_idx,
   input  logic                           entry_valid,
   input  logic                           entry_pinned,
   input  logic [KEY_BITS-1:0]            entry_key,
   input  logic [plkc_pkg::STAMP_W-1:0]   entry_stamp,
   input  logic [KEY_BITS-1:0]            probe_key,
   output plkc_pkg::scan_result_type      result
);

   import plkc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic               match_found_ff, match_found_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               old_found_ff, old_found_in;
   logic [IDX_W-1:0]   old_idx_ff, old_idx_in;
   logic [STAMP_W-1:0] old_stamp_ff, old_stamp_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [CNT_W-1:0]   pinned_ff, pinned_in;
   logic               usable;

   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in = match_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in = free_idx_ff;
      old_found_in = old_found_ff;
      old_idx_in = old_idx_ff;
      old_stamp_in = old_stamp_ff;
      occ_in = occ_ff;
      pinned_in = pinned_ff;
      usable = entry_valid && !entry_pinned;
      if (init) begin
         match_found_in = 1'b0;
         free_found_in = 1'b0;
         old_found_in = 1'b0;
         occ_in = '0;
         pinned_in = '0;
      end else if (step) begin
         if (usable && !match_found_ff && entry_key == probe_key) begin
            match_found_in = 1'b1;
            match_idx_in = step_idx;
         end
         if (!entry_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in = step_idx;
         end
         if (usable && (!old_found_ff || entry_stamp < old_stamp_ff)) begin
            old_found_in = 1'b1;
            old_idx_in = step_idx;
            old_stamp_in = entry_stamp;
         end
         if (entry_valid) begin
            occ_in = occ_ff + CNT_W'(1);
         end
         if (entry_valid && entry_pinned) begin
            pinned_in = pinned_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         old_found_ff <= 1'b0;
         occ_ff <= '0;
         pinned_ff <= '0;
      end else begin
         match_found_ff <= match_found_in;
         free_found_ff <= free_found_in;
         old_found_ff <= old_found_in;
         occ_ff <= occ_in;
         pinned_ff <= pinned_in;
      end
      match_idx_ff <= match_idx_in;
      free_idx_ff <= free_idx_in;
      old_idx_ff <= old_idx_in;
      old_stamp_ff <= old_stamp_in;
   end

   always_comb begin
      result.match_found = match_found_ff;
      result.match_slot = SLOT_MAX_W'(match_idx_ff);
      result.free_found = free_found_ff;
      result.free_slot = SLOT_MAX_W'(free_idx_ff);
      result.old_found = old_found_ff;
      result.old_slot = SLOT_MAX_W'(old_idx_ff);
      result.occupied = COUNT_MAX_W'(occ_ff);
      result.pinned_count = COUNT_MAX_W'(pinned_ff);
   end

endmodule

/* rtl/core/pinned_lru_key_cache_core.sv */
// Top level of the pinned LRU key cache: command sequencer, entry flags and counters.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+--------------------------------------------
//  request  | start, busy                     | req_cmd, req_lookup_key, req_slot_id, req_now
//  response | rsp_strobe                      | rsp_status ... rsp_occupied
//  control  | csr_write_enable                | csr_write_data (capacity)
//
// Each command walks the active entries once through the key and stamp RAM, one per cycle.
// Busy holds through the scan, drain and finish states after the accepting edge, and the
// strobe follows; the RAM read port and the one compare unit set the length of a beat.
// Reset clears the flags and counters and restores full capacity; the key and stamp RAM is kept.
// The response beat is shown for one cycle and the receiver cannot stall it.
module pinned_lru_key_cache_core #(
   parameter int ENTRIES = plkc_pkg::DEFAULT_ENTRIES,
   parameter int KEY_BITS = plkc_pkg::DEFAULT_KEY_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [plkc_pkg::CMD_W-1:0]       req_cmd,
   input  logic [plkc_pkg::REQ_KEY_W-1:0]   req_lookup_key,
   input  logic [plkc_pkg::SLOT_W-1:0]      req_slot_id,
   input  logic [plkc_pkg::STAMP_W-1:0]     req_now,
   input  logic                             csr_write_enable,
   input  logic [plkc_pkg::CAP_W-1:0]       csr_write_data,
   output logic                             rsp_strobe,
   output logic [plkc_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_hit,
   output logic [plkc_pkg::SLOT_W-1:0]      rsp_slot,
   output logic                             rsp_evicted,
   output logic [plkc_pkg::SLOT_W-1:0]      rsp_evicted_slot,
   output logic [plkc_pkg::CTR_W-1:0]       rsp_lookups,
   output logic [plkc_pkg::CTR_W-1:0]       rsp_hits,
   output logic [plkc_pkg::CTR_W-1:0]       rsp_misses,
   output logic [plkc_pkg::CTR_W-1:0]       rsp_evictions,
   output logic [plkc_pkg::OCC_W-1:0]       rsp_occupied
);

   import plkc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int LINE_W = KEY_BITS + STAMP_W;

   seq_state_type         state_ff, state_in;
   cmd_type               cmd_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [SLOT_W-1:0]     sid_ff;
   logic [STAMP_W-1:0]    now_ff;
   logic [CNT_W-1:0]      cap_ff;
   logic [CNT_W-1:0]      cap_eff;
   logic [CMP_W-1:0]      cap_wide;
   logic [CAP_W-1:0]      capacity_ff, capacity_in;
   logic [IDX_W-1:0]      issue_ff, issue_in;
   logic                  step_ff, step_in;
   logic [IDX_W-1:0]      step_idx_ff, step_idx_in;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [ENTRIES-1:0]    pinned_ff, pinned_in;
   logic [CTR_W-1:0]      lookups_ff, lookups_in;
   logic [CTR_W-1:0]      hits_ff, hits_in;
   logic [CTR_W-1:0]      misses_ff, misses_in;
   logic [CTR_W-1:0]      evictions_ff, evictions_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                  rsp_evicted_ff, rsp_evicted_in;
   logic [SLOT_W-1:0]     rsp_evicted_slot_ff, rsp_evicted_slot_in;
   logic [OCC_W-1:0]      rsp_occupied_ff, rsp_occupied_in;
   logic                  accept;
   logic                  scan_init;
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic                  ram_rd_en;
   logic [LINE_W-1:0]     ram_rd_data;
   scan_result_type       scan_res;
   logic [IDX_W-1:0]      match_idx, free_idx, old_idx, sid_idx, fill_idx;
   logic [CNT_W-1:0]      scan_occ, scan_pinned;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cap_wide = CMP_W'(capacity_ff);
      if (cap_wide == '0) begin
         cap_eff = CNT_W'(1);
      end else if (cap_wide > CMP_W'(ENTRIES)) begin
         cap_eff = CNT_W'(ENTRIES);
      end else begin
         cap_eff = CNT_W'(cap_wide);
      end
   end

   plkc_ram #(
      .WIDTH(LINE_W),
      .DEPTH(ENTRIES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data ({key_ff, now_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_ff),
      .rd_data (ram_rd_data)
   );

   plkc_scan #(
      .ENTRIES(ENTRIES),
      .KEY_BITS(KEY_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .init         (scan_init),
      .step         (step_ff),
      .step_idx     (step_idx_ff),
      .entry_valid  (valid_ff[step_idx_ff]),
      .entry_pinned (pinned_ff[step_idx_ff]),
      .entry_key    (ram_rd_data[LINE_W-1:STAMP_W]),
      .entry_stamp  (ram_rd_data[STAMP_W-1:0]),
      .probe_key    (key_ff),
      .result       (scan_res)
   );

   assign match_idx = IDX_W'(scan_res.match_slot);
   assign free_idx = IDX_W'(scan_res.free_slot);
   assign old_idx = IDX_W'(scan_res.old_slot);
   assign scan_occ = CNT_W'(scan_res.occupied);
   assign scan_pinned = CNT_W'(scan_res.pinned_count);
   assign sid_idx = IDX_W'(sid_ff);
   assign ram_rd_en = (state_ff == ST_SCAN);

   always_comb begin
      state_in = state_ff;
      capacity_in = csr_write_enable ? csr_write_data : capacity_ff;
      issue_in = issue_ff;
      step_in = 1'b0;
      step_idx_in = step_idx_ff;
      valid_in = valid_ff;
      pinned_in = pinned_ff;
      lookups_in = lookups_ff;
      hits_in = hits_ff;
      misses_in = misses_ff;
      evictions_in = evictions_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in = rsp_hit_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_evicted_slot_in = rsp_evicted_slot_ff;
      rsp_occupied_in = rsp_occupied_ff;
      scan_init = 1'b0;
      ram_we = 1'b0;
      ram_wr_addr = match_idx;
      fill_idx = free_idx;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
               issue_in = '0;
               scan_init = 1'b1;
            end
         end
         ST_SCAN: begin
            step_in = 1'b1;
            step_idx_in = issue_ff;
            if (CNT_W'(issue_ff) == cap_ff - CNT_W'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               issue_in = issue_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_hit_in = 1'b0;
            rsp_slot_in = '0;
            rsp_evicted_in = 1'b0;
            rsp_evicted_slot_in = '0;
            rsp_occupied_in = OCC_W'(scan_occ);
            unique case (cmd_ff)
               CMD_LOOKUP: begin
                  lookups_in = lookups_ff + CTR_W'(1);
                  if (scan_res.match_found) begin
                     pinned_in[match_idx] = 1'b1;
                     ram_we = 1'b1;
                     ram_wr_addr = match_idx;
                     hits_in = hits_ff + CTR_W'(1);
                     rsp_hit_in = 1'b1;
                     rsp_slot_in = SLOT_W'(match_idx);
                  end else begin
                     misses_in = misses_ff + CTR_W'(1);
                     if (scan_res.free_found) begin
                        fill_idx = free_idx;
                        rsp_occupied_in = OCC_W'(scan_occ + CNT_W'(1));
                     end else begin
                        fill_idx = old_idx;
                     end
                     if (!scan_res.free_found && scan_res.old_found) begin
                        evictions_in = evictions_ff + CTR_W'(1);
                        rsp_evicted_in = 1'b1;
                        rsp_evicted_slot_in = SLOT_W'(old_idx);
                     end
                     if (scan_res.free_found || scan_res.old_found) begin
                        valid_in[fill_idx] = 1'b1;
                        pinned_in[fill_idx] = 1'b1;
                        ram_we = 1'b1;
                        ram_wr_addr = fill_idx;
                        rsp_slot_in = SLOT_W'(fill_idx);
                     end else begin
                        rsp_status_in = STATUS_UNCACHED;
                     end
                  end
               end
               CMD_RELEASE: begin
                  if (CMP_W'(sid_ff) < CMP_W'(cap_ff) && valid_ff[sid_idx]) begin
                     pinned_in[sid_idx] = 1'b0;
                  end else begin
                     rsp_status_in = STATUS_ERROR;
                  end
               end
               CMD_CLEAR: begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (CNT_W'(i) < cap_ff && !pinned_ff[i]) begin
                        valid_in[i] = 1'b0;
                     end
                  end
                  rsp_occupied_in = OCC_W'(scan_pinned);
               end
               CMD_EVICT: begin
                  if (scan_res.old_found) begin
                     valid_in[old_idx] = 1'b0;
                     evictions_in = evictions_ff + CTR_W'(1);
                     rsp_evicted_in = 1'b1;
                     rsp_evicted_slot_in = SLOT_W'(old_idx);
                     rsp_occupied_in = OCC_W'(scan_occ - CNT_W'(1));
                  end else begin
                     rsp_status_in = STATUS_ERROR;
                  end
               end
               CMD_STATS: begin
                  rsp_status_in = STATUS_OK;
               end
               default: begin
                  rsp_status_in = STATUS_ERROR;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         capacity_ff <= CAPACITY_RESET;
         step_ff <= 1'b0;
         valid_ff <= '0;
         pinned_ff <= '0;
         lookups_ff <= '0;
         hits_ff <= '0;
         misses_ff <= '0;
         evictions_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         capacity_ff <= capacity_in;
         step_ff <= step_in;
         valid_ff <= valid_in;
         pinned_ff <= pinned_in;
         lookups_ff <= lookups_in;
         hits_ff <= hits_in;
         misses_ff <= misses_in;
         evictions_ff <= evictions_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      issue_ff <= issue_in;
      step_idx_ff <= step_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_evicted_slot_ff <= rsp_evicted_slot_in;
      rsp_occupied_ff <= rsp_occupied_in;
      if (accept) begin
         cmd_ff <= cmd_type'(req_cmd);
         key_ff <= KEY_BITS'(req_lookup_key);
         sid_ff <= req_slot_id;
         now_ff <= req_now;
         cap_ff <= cap_eff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_slot = rsp_slot_ff;
   assign rsp_evicted = rsp_evicted_ff;
   assign rsp_evicted_slot = rsp_evicted_slot_ff;
   assign rsp_lookups = lookups_ff;
   assign rsp_hits = hits_ff;
   assign rsp_misses = misses_ff;
   assign rsp_evictions = evictions_ff;
   assign rsp_occupied = rsp_occupied_ff;

endmodule
